// ===== hw/rtl/bc_pkg.sv =====
// Shared types, constants and tables for the balance controller.
`default_nettype none
package bc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUSION_FACTOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SMOOTHING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY       = 3'd4;

  // Q8.16 constants
  localparam int K_0P2   = 13107;
  localparam int K_0P05  = 3277;
  localparam int K_0P4   = 26214;
  localparam int K_0P04  = 2621;
  localparam int K_0P7   = 45875;
  localparam int K_0P3   = 19661;
  localparam int K_1P2   = 78643;
  localparam int K_ONE   = 65536;
  // 0.07 * 2 (steering Q1.15 to Q8.16) in Q8.16
  localparam int K_STEER = 9176;

  localparam int CORDIC_MAX = 24;
  localparam int XW         = 36;
  localparam int NUMW       = 29;
  localparam int NMATH      = 14;

  localparam logic signed [XW-1:0] PI_Q30 = 36'sd3373259426;

  typedef struct packed {
    logic [22:0] max_speed;
    logic [15:0] fusion_factor;
    logic [15:0] rate_smoothing;
    logic [15:0] time_step;
    logic [14:0] max_duty;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DSET, ST_DIV, ST_CORD, ST_MATH, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DSET, OP_DIV, OP_CORDIC,
    OP_ATAN, OP_TILT_A, OP_TILT_B, OP_TILT_C, OP_RATE_A, OP_RATE_B,
    OP_LIM_A, OP_LIM_B, OP_TORQ, OP_STAB_A, OP_STAB_B,
    OP_DRV_A, OP_DRV_B, OP_DRV_C, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  function automatic op_t math_op(input logic [3:0] i);
    op_t o;
    unique case (i)
      4'd0:    o = OP_ATAN;
      4'd1:    o = OP_TILT_A;
      4'd2:    o = OP_TILT_B;
      4'd3:    o = OP_TILT_C;
      4'd4:    o = OP_RATE_A;
      4'd5:    o = OP_RATE_B;
      4'd6:    o = OP_LIM_A;
      4'd7:    o = OP_LIM_B;
      4'd8:    o = OP_TORQ;
      4'd9:    o = OP_STAB_A;
      4'd10:   o = OP_STAB_B;
      4'd11:   o = OP_DRV_A;
      4'd12:   o = OP_DRV_B;
      4'd13:   o = OP_DRV_C;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    unique case (i)
      5'd0:    a = 30'd843314856;
      5'd1:    a = 30'd497837829;
      5'd2:    a = 30'd263043836;
      5'd3:    a = 30'd133525158;
      5'd4:    a = 30'd67021686;
      5'd5:    a = 30'd33543515;
      5'd6:    a = 30'd16775850;
      5'd7:    a = 30'd8388437;
      5'd8:    a = 30'd4194282;
      5'd9:    a = 30'd2097149;
      5'd10:   a = 30'd1048575;
      5'd11:   a = 30'd524287;
      5'd12:   a = 30'd262143;
      5'd13:   a = 30'd131071;
      5'd14:   a = 30'd65535;
      5'd15:   a = 30'd32767;
      5'd16:   a = 30'd16383;
      5'd17:   a = 30'd8191;
      5'd18:   a = 30'd4095;
      5'd19:   a = 30'd2047;
      5'd20:   a = 30'd1023;
      5'd21:   a = 30'd511;
      5'd22:   a = 30'd255;
      5'd23:   a = 30'd127;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bc_ctrl.sv =====
// Sequencer for the balance controller: load, divide, CORDIC, arithmetic, output.
`default_nettype none
module bc_ctrl import bc_pkg::*; #(
  parameter int STATE_WIDTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam int NW    = ((STATE_WIDTH > NUMW) ? STATE_WIDTH : NUMW) + 1;
  localparam int NSTEP = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
  localparam int CW    = $clog2(NW);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.idx   = cnt_r[4:0];
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DSET;
        end
      end
      ST_DSET: begin
        cmd.op    = OP_DSET;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == CW'(NW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_CORD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CORD: begin
        cmd.op = OP_CORDIC;
        if (cnt_r == CW'(NSTEP - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_MATH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MATH: begin
        cmd.op = math_op(cnt_r[3:0]);
        if (cnt_r == CW'(NMATH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bc_dp.sv =====
// Datapath: CORDIC atan2, restoring divider, shared rounding multiplier, state.
`default_nettype none
module bc_dp import bc_pkg::*; #(
  parameter int STATE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire cfg_t               cfg,
  input  wire logic signed [15:0] in_steering,
  input  wire logic signed [15:0] in_gyro_rate,
  input  wire logic signed [15:0] in_accel_horizontal,
  input  wire logic signed [15:0] in_accel_vertical,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_left_duty,
  output logic signed [15:0]      out_right_duty
);

  localparam int SW = STATE_WIDTH;
  localparam int MW = SW + 2;
  localparam int PW = SW + 18;
  localparam int WW = SW + 4;
  localparam int NW = ((SW > NUMW) ? SW : NUMW) + 1;

  localparam logic signed [WW-1:0] SMAX = {{(WW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [WW-1:0] SMIN = ~SMAX;

  function automatic logic signed [SW-1:0] sat_f(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    if (v > SMAX) r = SMAX;
    else if (v < SMIN) r = SMIN;
    else r = v;
    return r[SW-1:0];
  endfunction

  // architectural state
  logic signed [SW-1:0] tilt_r, fr_r, stable_r, li_r, dv_r;
  logic signed [SW-1:0] tilt_nxt, fr_nxt, stable_nxt, li_nxt, dv_nxt;
  // working registers
  logic signed [SW-1:0] rate_r, acc_r, a_r, tq5_r, ov_r, torque_r, t12_r;
  logic signed [MW-1:0] sum_r, m_r;
  logic                 ovp_r, zero_r, nsgn_r;
  logic signed [XW-1:0] x_r, y_r, z_r;
  logic [NUMW-1:0]      numa_r;
  logic [SW-1:0]        den_r, rem_r;
  logic [NW-1:0]        nq_r;
  logic                 out_valid_r;
  logic signed [15:0]   left_r, right_r;

  // shared multiplier: round(mv * mc / 2^16), half up
  logic signed [SW-1:0] mv;
  logic [16:0]          mc;
  logic signed [PW-1:0] prod, rsum;

  always_comb begin
    mv = '0;
    mc = '0;
    unique case (cmd.op)
      OP_ATAN:   begin mv = rate_r;   mc = 17'(cfg.time_step); end
      OP_TILT_A: begin mv = acc_r;    mc = 17'(K_ONE) - 17'(cfg.fusion_factor); end
      OP_TILT_B: begin mv = a_r;      mc = 17'(cfg.fusion_factor); end
      OP_TILT_C: begin mv = rate_r;   mc = 17'(cfg.rate_smoothing); end
      OP_RATE_A: begin mv = fr_r;     mc = 17'(K_ONE) - 17'(cfg.rate_smoothing); end
      OP_LIM_A:  begin
        mv = ovp_r ? ov_r : SW'(K_0P04);
        mc = 17'(cfg.time_step);
      end
      OP_LIM_B:  begin mv = fr_r;     mc = 17'(K_0P2); end
      OP_TORQ:   begin mv = ov_r;     mc = 17'(K_0P4); end
      OP_STAB_A: begin mv = li_r;     mc = 17'(K_0P7); end
      OP_STAB_B: begin mv = torque_r; mc = 17'(K_1P2); end
      OP_DRV_B:  begin mv = t12_r;    mc = 17'(cfg.time_step); end
      default:   begin mv = '0;       mc = '0; end
    endcase
  end

  assign prod = mv * $signed({1'b0, mc});
  assign rsum = prod + PW'(32768);

  // load-time values
  logic [16:0]          steer_abs;
  logic signed [16:0]   nav, nah;
  logic signed [XW-1:0] x0, y0;
  logic [SW-1:0]        dv_abs;

  assign steer_abs = in_steering[15] ? 17'(-(17'(in_steering))) : 17'(in_steering);
  assign nav       = -(17'(in_accel_vertical));
  assign nah       = -(17'(in_accel_horizontal));
  assign x0        = XW'(nav) <<< 14;
  assign y0        = XW'(nah) <<< 14;
  assign dv_abs    = dv_r[SW-1] ? SW'(-dv_r) : SW'(dv_r);

  // CORDIC step
  logic signed [XW-1:0] dx, dy, at;
  assign dx = y_r >>> cmd.idx;
  assign dy = x_r >>> cmd.idx;
  assign at = $signed({6'b0, atan_q30(cmd.idx)});

  logic signed [XW-1:0] zr;
  assign zr = z_r + XW'(8192);

  // divider step
  logic [SW:0] dtrial;
  logic        dge;
  assign dtrial = {rem_r, nq_r[NW-1]};
  assign dge    = dtrial >= {1'b0, den_r};

  // speed limiter pre-computation
  logic signed [WW-1:0] over, ovs, d5, dsum;
  assign over = WW'(dv_r) - WW'($signed({1'b0, cfg.max_speed}));
  assign ovs  = over + WW'(K_0P05);
  assign dsum = WW'(tilt_r) - WW'(stable_r);
  assign d5   = (dsum <<< 2) + dsum;

  logic signed [SW-1:0] li_inc;
  assign li_inc = sat_f(WW'(li_r) + WW'(m_r));

  // duty conversion
  logic signed [16:0]   sadj;
  logic signed [WW-1:0] vb, vl, vr, hl, hr, mx;
  logic signed [15:0]   dl, dr;
  assign sadj = nsgn_r ? -(17'(nq_r[15:0])) : 17'(nq_r[15:0]);
  assign vb   = WW'(torque_r) + WW'(dv_r);
  assign vl   = vb + WW'(sadj);
  assign vr   = vb - WW'(sadj);
  assign hl   = (vl + WW'(1)) >>> 1;
  assign hr   = (vr + WW'(1)) >>> 1;
  assign mx   = WW'($signed({1'b0, cfg.max_duty}));

  always_comb begin
    if (hl > mx) dl = mx[15:0];
    else if (hl < -mx) dl = 16'(-mx);
    else dl = hl[15:0];
    if (hr > mx) dr = mx[15:0];
    else if (hr < -mx) dr = 16'(-mx);
    else dr = hr[15:0];
  end

  always_comb begin
    tilt_nxt   = tilt_r;
    fr_nxt     = fr_r;
    stable_nxt = stable_r;
    li_nxt     = li_r;
    dv_nxt     = dv_r;
    unique case (cmd.op)
      OP_TILT_C: tilt_nxt = sat_f(WW'(sum_r) + WW'(m_r));
      OP_RATE_B: fr_nxt   = sat_f(WW'(sum_r) + WW'(m_r));
      OP_LIM_B: begin
        if (ovp_r) begin
          li_nxt = (li_inc > SW'(K_0P4)) ? SW'(K_0P4) : li_inc;
        end else if (li_r > 0) begin
          li_nxt = sat_f(WW'(li_r) - WW'(m_r));
        end
      end
      OP_STAB_B: stable_nxt = sat_f(WW'(sum_r) + WW'(m_r));
      OP_DRV_C:  dv_nxt     = sat_f(WW'(dv_r) + WW'(m_r));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_r      <= '0;
      fr_r        <= '0;
      stable_r    <= '0;
      li_r        <= '0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tilt_r   <= tilt_nxt;
      fr_r     <= fr_nxt;
      stable_r <= stable_nxt;
      li_r     <= li_nxt;
      dv_r     <= dv_nxt;
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= rsum[16 +: MW];
    unique case (cmd.op)
      OP_LOAD: begin
        rate_r <= SW'(in_gyro_rate) <<< 4;
        nsgn_r <= in_steering[15];
        numa_r <= NUMW'(steer_abs) * NUMW'(K_STEER);
        den_r  <= dv_abs + SW'(K_0P3);
        zero_r <= (in_accel_horizontal == '0) && (in_accel_vertical == '0);
        if (x0 < 0) begin
          x_r <= -x0;
          y_r <= -y0;
          z_r <= (y0 >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
          x_r <= x0;
          y_r <= y0;
          z_r <= '0;
        end
      end
      OP_DSET: begin
        nq_r  <= NW'(numa_r) + NW'(den_r >> 1);
        rem_r <= '0;
      end
      OP_DIV: begin
        rem_r <= dge ? SW'(dtrial - {1'b0, den_r}) : dtrial[SW-1:0];
        nq_r  <= {nq_r[NW-2:0], dge};
      end
      OP_CORDIC: begin
        if (y_r > 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end
      end
      OP_ATAN:   acc_r <= zero_r ? '0 : SW'(zr >>> 14);
      OP_TILT_A: a_r   <= sat_f(WW'(tilt_r) + WW'(m_r));
      OP_TILT_B: sum_r <= m_r;
      OP_RATE_A: sum_r <= m_r;
      OP_RATE_B: begin
        tq5_r <= sat_f(d5);
        ovp_r <= over > 0;
        if (over > 0) ov_r <= (ovs > WW'(K_0P2)) ? SW'(K_0P2) : ovs[SW-1:0];
        else ov_r <= '0;
      end
      OP_TORQ:   torque_r <= sat_f(WW'(tq5_r) + WW'(m_r));
      OP_STAB_A: sum_r    <= m_r;
      OP_DRV_A:  t12_r    <= sat_f(WW'(m_r));
      OP_OUT: begin
        left_r  <= dl;
        right_r <= dr;
      end
      default: ;
    endcase
  end

  assign stat.out_busy  = out_valid_r && out_stall;
  assign out_valid      = out_valid_r;
  assign out_left_duty  = left_r;
  assign out_right_duty = right_r;

`ifndef SYNTH
  a_li_cap: assert property (@(posedge clk) disable iff (!rst_n)
    li_r <= SW'(K_0P4))
    else $error("limiter integral above cap");
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (nq_r < NW'(32768)))
    else $error("steering quotient out of range");
  a_cordic_x: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_CORDIC) |-> !x_r[XW-1])
    else $error("CORDIC x went negative");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_OUT))
    else $error("result raised without output step");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/balance_controller_step.sv =====
// Sequence: load, divider setup, bit-serial steering divide, CORDIC, the
//   arithmetic steps, then output; NW = max(STATE_WIDTH, 29) + 1 divider bits.
// One transaction at a time, paced by the bit-serial steering divider and the
//   one-step-per-cycle CORDIC; the output step waits while a result is stalled.
// Reset (rst_n low, synchronous): filter state zero, registers to defaults,
//   no result pending.
`default_nettype none
module balance_controller_step import bc_pkg::*; #(
  parameter int STATE_WIDTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [15:0]    in_steering,
  input  wire logic signed [15:0]    in_gyro_rate,
  input  wire logic signed [15:0]    in_accel_horizontal,
  input  wire logic signed [15:0]    in_accel_vertical,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [15:0]         out_left_duty,
  output logic signed [15:0]         out_right_duty,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed      <= 23'd32768;
      cfg_r.fusion_factor  <= 16'd64880;
      cfg_r.rate_smoothing <= 16'd58982;
      cfg_r.time_step      <= 16'd655;
      cfg_r.max_duty       <= 15'd31130;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_SPEED:      cfg_r.max_speed      <= cfg_data;
        CFG_FUSION_FACTOR:  cfg_r.fusion_factor  <= cfg_data[15:0];
        CFG_RATE_SMOOTHING: cfg_r.rate_smoothing <= cfg_data[15:0];
        CFG_TIME_STEP:      cfg_r.time_step      <= cfg_data[15:0];
        CFG_MAX_DUTY:       cfg_r.max_duty       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  bc_ctrl #(
    .STATE_WIDTH (STATE_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  bc_dp #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg                (cfg_r),
    .in_steering        (in_steering),
    .in_gyro_rate       (in_gyro_rate),
    .in_accel_horizontal(in_accel_horizontal),
    .in_accel_vertical  (in_accel_vertical),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_duty      (out_left_duty),
    .out_right_duty     (out_right_duty)
  );

endmodule
`default_nettype wire
